// ----- src/tcc_pkg.sv -----
// shared constants, types and tables of the tilt compensated compass
package tcc_pkg;

  // default parameter values
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int SAMPLE_BITS_DEF     = 16;

  // arithmetic widths
  localparam int MUL_W    = 32;
  localparam int ACC_W    = 2 * MUL_W + 2;
  localparam int ZW       = 34;
  localparam int HW       = 35;
  localparam int RAD_FRAC = 7;
  localparam int ITERS    = 28;
  localparam int IT_W     = 5;

  // angle constants in q30 radians
  localparam longint Q30_PI       = 64'sd3373259426;
  localparam longint Q30_HALF_PI  = 64'sd1686629713;
  localparam longint Q30_TWO_PI   = 64'sd6746518852;
  localparam longint INV_GAIN_Q30 = 64'sd652032874;

  // cordic unit control and status
  typedef struct packed {
    logic start;
    logic rot_mode;
  } cor_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // arctangent of 2^-i in q30
  function automatic logic signed [ZW-1:0] atan_entry(input logic [IT_W-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      5'd24: v = 34'sd63;
      5'd25: v = 34'sd31;
      5'd26: v = 34'sd15;
      5'd27: v = 34'sd8;
      default: v = '0;
    endcase
    return v;
  endfunction

  // first quadrant angle limited to [0, pi/2]
  function automatic logic signed [ZW-1:0] vec_clamp(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] v;
    if (z < 0) begin
      v = '0;
    end else if (z > ZW'(Q30_HALF_PI)) begin
      v = ZW'(Q30_HALF_PI);
    end else begin
      v = z;
    end
    return v;
  endfunction

  // sector bound in milliradians rounded to the output format
  function automatic longint sector_bound(input longint milli, input int frac);
    return ((milli << frac) + 500) / 1000;
  endfunction

endpackage

// ----- src/tcc_if.sv -----
// valid/ready channels for sensor samples and compass results
interface tcc_in_if import tcc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic signed [SAMPLE_BITS-1:0] mag_x;
  logic signed [SAMPLE_BITS-1:0] mag_y;
  logic signed [SAMPLE_BITS-1:0] mag_z;

  modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [ANGLE_FRAC_BITS+1:0] pitch_angle;
  logic signed [ANGLE_FRAC_BITS+1:0] roll_angle;
  logic        [ANGLE_FRAC_BITS+2:0] heading_angle;
  logic        [2:0]                 lit_led;
  logic                              heading_fresh;

  modport source (output valid, pitch_angle, roll_angle, heading_angle, lit_led,
                  heading_fresh, input ready);
  modport sink (input valid, pitch_angle, roll_angle, heading_angle, lit_led,
                heading_fresh, output ready);
endinterface

// ----- src/tcc_cordic.sv -----
// iterative cordic unit, vectoring and rotation modes, one step per cycle
module tcc_cordic import tcc_pkg::*; #(
  parameter int CW = SAMPLE_BITS_DEF + 27
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cor_ctl_t             ctl_i,
  input  logic signed [CW-1:0] x0_i,
  input  logic signed [CW-1:0] y0_i,
  input  logic signed [ZW-1:0] z0_i,
  output unit_stat_t           stat_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  logic                 busy_q, done_q, rot_q;
  logic [IT_W-1:0]      step_q;
  logic signed [CW-1:0] x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q, za;
  logic                 neg;

  // micro-rotation direction and shifted terms
  always_comb begin
    dx  = x_q >>> step_q;
    dy  = y_q >>> step_q;
    za  = atan_entry(step_q);
    neg = rot_q ? !z_q[ZW-1] : y_q[CW-1];
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rot_q  <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        rot_q  <= ctl_i.rot_mode;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == IT_W'(ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  // vector registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q <= x0_i;
      y_q <= y0_i;
      z_q <= z0_i;
    end else if (busy_q) begin
      if (neg) begin
        x_q <= x_q - dy;
        y_q <= y_q + dx;
        z_q <= z_q - za;
      end else begin
        x_q <= x_q + dy;
        y_q <= y_q - dx;
        z_q <= z_q + za;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

  // a new start never lands on a running pass
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q) else $error("cordic restarted while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q || $past(ctl_i.start)) else $error("cordic done held");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("cordic done while busy");

endmodule

// ----- src/tcc_isqrt.sv -----
// bit-pair integer square root, one result bit per cycle
module tcc_isqrt import tcc_pkg::*; #(
  parameter int SQW = 2 * SAMPLE_BITS_DEF + 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SQW-1:0]     val_i,
  output unit_stat_t         stat_o,
  output logic [SQW/2-1:0]   root_o
);

  localparam int NIT   = SQW / 2;
  localparam int CNT_W = $clog2(NIT);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SQW-1:0]   rem_q, root_q, bit_q, trial;

  assign trial = root_q + bit_q;

  // iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NIT - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // remainder and root update
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= val_i;
      root_q <= '0;
      bit_q  <= SQW'(1) << (SQW - 2);
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q[SQW/2-1:0];

endmodule

// ----- src/tilt_compensated_compass.sv -----
// Tilt compensated compass: pitch, roll and heading from accel and mag samples.
//
// in_i takes one transaction per sample set (three accelerometer and three
// magnetometer axes); out_o gives one result transaction for each of them.
// Both are valid/ready channels; a transaction moves when valid and ready are
// high at a rising edge. cfg_we_i/cfg_data_i write the display mode (1 compass,
// 0 tilt readout of absolute pitch and roll); write it only while idle.
// Each sample set runs through one iterative square root unit (23 steps)
// twice and one 28-step cordic unit two times in tilt mode and five times in
// compass mode, plus a shared multiplier for squares and tilt compensation.
// An axis with zero numerator and zero root skips its cordic pass, and an
// undefined heading skips the heading pass. in_i is ready only while no sample
// set is in work, so a new set is not taken before the last one is done. The
// result sits in an output register; if the receiver stalls, the next sample
// set is still taken and computed, and it waits at its end until the output
// register is free. Reset (async, active low) selects compass mode and clears
// the held heading and lit LED to zero.
module tilt_compensated_compass import tcc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcc_in_if.sink    in_i,
  tcc_out_if.source out_o,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int S     = SAMPLE_BITS;
  localparam int CW    = S + 27;
  localparam int SQW   = 2 * S + 14;
  localparam int NW    = S + 1;
  localparam int SH    = 30 - F;
  localparam longint RND = longint'(1) << (29 - F);
  localparam logic [F+2:0] TP = (F+3)'((Q30_TWO_PI + RND) >> SH);
  localparam logic [F+2:0] B0 = (F+3)'(sector_bound(300, F));
  localparam logic [F+2:0] B1 = (F+3)'(sector_bound(1150, F));
  localparam logic [F+2:0] B2 = (F+3)'(sector_bound(2200, F));
  localparam logic [F+2:0] B3 = (F+3)'(sector_bound(3050, F));
  localparam logic [F+2:0] B4 = (F+3)'(sector_bound(3700, F));
  localparam logic [F+2:0] B5 = (F+3)'(sector_bound(4400, F));
  localparam logic [F+2:0] B6 = (F+3)'(sector_bound(5200, F));
  localparam logic [F+2:0] B7 = (F+3)'(sector_bound(5800, F));

  typedef enum logic [4:0] {
    S_IDLE, S_SQ0, S_SQ1, S_ROOT, S_ROOT_W, S_VEC, S_VEC_W, S_NEXT,
    S_ROT, S_ROT_W, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_HVEC, S_HVEC_W, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  state_e state_q;
  logic   axis_q, mode_q, fresh_q, out_valid_q;
  logic [F+2:0] held_heading_q;
  logic [2:0]   held_led_q;
  logic signed [F+1:0] pitch_o_q, roll_o_q;
  logic [F+2:0] heading_o_q;
  logic [2:0]   led_o_q;
  logic         fresh_o_q;

  logic signed [S-1:0] ax_q, ay_q, az_q, mx_q, my_q, mz_q;
  logic signed [ACC_W-1:0] acc_q, cx_q, prod;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [MUL_W-1:0] cp_q, sp_q, cr_q, sr_q, t1_q, t2_q;
  logic signed [ZW-1:0] pitch_q, roll_q;
  logic signed [CW-1:0] ux_q, uy_q;
  logic cyneg_q;
  acc_op_e acc_op;

  logic in_fire, out_fire, num_zero;
  logic signed [NW-1:0] num, nabs;
  logic signed [ZW-1:0] vang, sang;

  cor_ctl_t   cor_ctl;
  unit_stat_t cor_stat, sq_stat;
  logic signed [CW-1:0] cx0, cy0, cor_x, cor_y;
  logic signed [ZW-1:0] cz0, cor_z;
  logic sq_start;
  logic [SQW/2-1:0] sq_root;

  logic signed [HW-1:0] h, hsum;
  logic [F+2:0] hq_raw, hq;
  logic [2:0]   led;
  logic signed [ACC_W-1:0] cx_abs, cy_abs;
  logic signed [ZW-1:0] psum, rsum;
  logic signed [F+1:0] pq, rq;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  // shared iterative units
  tcc_cordic #(.CW(CW)) u_cordic (
    .clk_i, .rst_ni, .ctl_i(cor_ctl), .x0_i(cx0), .y0_i(cy0), .z0_i(cz0),
    .stat_o(cor_stat), .x_o(cor_x), .y_o(cor_y), .z_o(cor_z)
  );

  tcc_isqrt #(.SQW(SQW)) u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(SQW'(acc_q[2*S-1:0]) << 14),
    .stat_o(sq_stat), .root_o(sq_root)
  );

  // numerator of the current inclination and its magnitude
  always_comb begin
    num      = axis_q ? NW'(ay_q) : NW'(ax_q);
    nabs     = num[NW-1] ? -num : num;
    num_zero = (nabs == '0) && (sq_root == '0);
    vang     = vec_clamp(cor_z);
    sang     = num[NW-1] ? -vang : vang;
  end

  // unit starts and operands
  always_comb begin
    sq_start         = (state_q == S_ROOT);
    cor_ctl.start    = 1'b0;
    cor_ctl.rot_mode = 1'b0;
    cx0 = ux_q;
    cy0 = uy_q;
    cz0 = '0;
    unique case (state_q)
      S_VEC: begin
        cor_ctl.start = !num_zero;
        cx0 = CW'(sq_root) << 16;
        cy0 = CW'($unsigned(nabs)) << (RAD_FRAC + 16);
      end
      S_ROT: begin
        cor_ctl.start    = 1'b1;
        cor_ctl.rot_mode = 1'b1;
        cx0 = CW'(INV_GAIN_Q30);
        cy0 = '0;
        cz0 = axis_q ? roll_q : pitch_q;
      end
      S_HVEC: cor_ctl.start = 1'b1;
      default: ;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    acc_op = ACC_HOLD;
    unique case (state_q)
      S_SQ0: begin
        mul_a = axis_q ? MUL_W'(ax_q) : MUL_W'(ay_q);
        mul_b = mul_a;
        acc_op = ACC_LOAD;
      end
      S_SQ1: begin mul_a = MUL_W'(az_q); mul_b = MUL_W'(az_q); acc_op = ACC_ADD; end
      S_M1:  begin mul_a = sr_q; mul_b = sp_q; acc_op = ACC_LOAD; end
      S_M2:  begin mul_a = sr_q; mul_b = cp_q; acc_op = ACC_LOAD; end
      S_M3:  begin mul_a = MUL_W'(mx_q); mul_b = cp_q; acc_op = ACC_LOAD; end
      S_M4:  begin mul_a = MUL_W'(mz_q); mul_b = sp_q; acc_op = ACC_ADD; end
      S_M5:  begin mul_a = MUL_W'(mx_q); mul_b = t1_q; acc_op = ACC_LOAD; end
      S_M6:  begin mul_a = MUL_W'(my_q); mul_b = cr_q; acc_op = ACC_ADD; end
      S_M7:  begin mul_a = MUL_W'(mz_q); mul_b = t2_q; acc_op = ACC_SUB; end
      default: ;
    endcase
    // full width product, sign extended into the accumulator
    mul_p = mul_a * mul_b;
    prod  = ACC_W'(mul_p);
  end

  // heading quadrant, rounding and led sector
  always_comb begin
    logic signed [HW-1:0] a;
    a = HW'(vang);
    if (!cx_q[ACC_W-1] && !cyneg_q) begin
      h = a;
    end else if (cx_q[ACC_W-1] && !cyneg_q) begin
      h = HW'(Q30_PI) - a;
    end else if (cx_q[ACC_W-1]) begin
      h = HW'(Q30_PI) + a;
    end else begin
      h = HW'(Q30_TWO_PI) - a;
    end
    hsum   = (h + HW'(RND)) >>> SH;
    hq_raw = hsum[F+2:0];
    hq     = (hq_raw >= TP) ? hq_raw - TP : hq_raw;
    priority if (hq >= B0 && hq < B1) led = 3'd3;
    else if (hq >= B1 && hq < B2) led = 3'd2;
    else if (hq >= B2 && hq < B3) led = 3'd1;
    else if (hq >= B3 && hq < B4) led = 3'd0;
    else if (hq >= B4 && hq < B5) led = 3'd7;
    else if (hq >= B5 && hq < B6) led = 3'd6;
    else if (hq >= B6 && hq < B7) led = 3'd5;
    else led = 3'd4;
  end

  // output angle rounding and magnitudes of the compensated components
  always_comb begin
    psum   = (pitch_q + ZW'(RND)) >>> SH;
    rsum   = (roll_q + ZW'(RND)) >>> SH;
    pq     = psum[F+1:0];
    rq     = rsum[F+1:0];
    cx_abs = cx_q[ACC_W-1] ? -cx_q : cx_q;
    cy_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
  end

  // sequencer, held heading and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      axis_q         <= 1'b0;
      mode_q         <= 1'b1;
      fresh_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      held_heading_q <= '0;
      held_led_q     <= '0;
      pitch_o_q      <= '0;
      roll_o_q       <= '0;
      heading_o_q    <= '0;
      led_o_q        <= '0;
      fresh_o_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (out_fire && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            axis_q  <= 1'b0;
            fresh_q <= 1'b0;
            state_q <= S_SQ0;
          end
        end
        S_SQ0:    state_q <= S_SQ1;
        S_SQ1:    state_q <= S_ROOT;
        S_ROOT:   state_q <= S_ROOT_W;
        S_ROOT_W: if (sq_stat.done) state_q <= S_VEC;
        S_VEC:    state_q <= num_zero ? S_NEXT : S_VEC_W;
        S_VEC_W:  if (cor_stat.done) state_q <= S_NEXT;
        S_NEXT: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= S_SQ0;
          end else if (mode_q) begin
            axis_q  <= 1'b0;
            state_q <= S_ROT;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_ROT:    state_q <= S_ROT_W;
        S_ROT_W: begin
          if (cor_stat.done) begin
            axis_q  <= 1'b1;
            state_q <= axis_q ? S_M1 : S_ROT;
          end
        end
        S_M1: state_q <= S_M2;
        S_M2: state_q <= S_M3;
        S_M3: state_q <= S_M4;
        S_M4: state_q <= S_M5;
        S_M5: state_q <= S_M6;
        S_M6: state_q <= S_M7;
        S_M7: state_q <= S_M8;
        S_M8: begin
          if ((cx_abs >>> 7) == '0 && (cy_abs >>> 7) == '0) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_HVEC;
          end
        end
        S_HVEC: state_q <= S_HVEC_W;
        S_HVEC_W: begin
          if (cor_stat.done) begin
            held_heading_q <= hq;
            held_led_q     <= led;
            fresh_q        <= 1'b1;
            state_q        <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            pitch_o_q   <= (!mode_q && pq[F+1]) ? -pq : pq;
            roll_o_q    <= (!mode_q && rq[F+1]) ? -rq : rq;
            heading_o_q <= held_heading_q;
            led_o_q     <= held_led_q;
            fresh_o_q   <= fresh_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ax_q <= in_i.accel_x;
      ay_q <= in_i.accel_y;
      az_q <= in_i.accel_z;
      mx_q <= in_i.mag_x;
      my_q <= in_i.mag_y;
      mz_q <= in_i.mag_z;
    end
    unique case (acc_op)
      ACC_LOAD: acc_q <= prod;
      ACC_ADD:  acc_q <= acc_q + prod;
      ACC_SUB:  acc_q <= acc_q - prod;
      ACC_HOLD: acc_q <= acc_q;
    endcase
    // inclination angles
    if ((state_q == S_VEC && num_zero) || (state_q == S_VEC_W && cor_stat.done)) begin
      if (axis_q) begin
        roll_q <= (state_q == S_VEC) ? '0 : sang;
      end else begin
        pitch_q <= (state_q == S_VEC) ? '0 : sang;
      end
    end
    // sine and cosine of the tilt
    if (state_q == S_ROT_W && cor_stat.done) begin
      if (axis_q) begin
        cr_q <= cor_x[MUL_W-1:0];
        sr_q <= cor_y[MUL_W-1:0];
      end else begin
        cp_q <= cor_x[MUL_W-1:0];
        sp_q <= cor_y[MUL_W-1:0];
      end
    end
    // floored q30 products and compensated components
    if (state_q == S_M2) t1_q <= acc_q[30 +: MUL_W];
    if (state_q == S_M3) t2_q <= acc_q[30 +: MUL_W];
    if (state_q == S_M5) cx_q <= acc_q;
    if (state_q == S_M8) begin
      ux_q    <= CW'(cx_abs >>> 7);
      uy_q    <= CW'(cy_abs >>> 7);
      cyneg_q <= acc_q[ACC_W-1];
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.pitch_angle   = pitch_o_q;
  assign out_o.roll_angle    = roll_o_q;
  assign out_o.heading_angle = heading_o_q;
  assign out_o.lit_led       = led_o_q;
  assign out_o.heading_fresh = fresh_o_q;

  // a taken transaction keeps the block busy
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready) else $error("ready right after a transaction");
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.heading_fresh |-> out_o.heading_angle < TP)
    else $error("heading outside a full turn");
  a_fresh_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.heading_fresh |-> mode_q) else $error("fresh heading in tilt mode");
  a_sqrt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_stat.busy && !cor_stat.busy) else $error("root start while busy");

endmodule

// ----- tb/sv/tb_tilt_compensated_compass.sv -----
// testbench of the tilt compensated compass: bit-exact predictor with scoreboard
module tb_tilt_compensated_compass;
  import tcc_pkg::*;

  localparam int AFB = ANGLE_FRAC_BITS_DEF;
  localparam int SB = SAMPLE_BITS_DEF;
  localparam int RADF = 7;
  localparam int STEPS = 28;
  localparam int STALL_LIMIT = 20000;
  localparam logic MODE_TILT = 1'b0;
  localparam logic MODE_COMPASS = 1'b1;

  // one result as the block reports it
  typedef struct packed {
    logic [14:0] pitch;
    logic [14:0] roll;
    logic [15:0] heading;
    logic [2:0]  led;
    logic        fresh;
  } heading_res_t;

  // one input transaction
  typedef struct packed {
    logic signed [SB-1:0] ax, ay, az, mx, my, mz;
  } sample_set_t;

  // expected results waiting for the output channel
  class compass_scoreboard;
    heading_res_t pending[$];
    int           errors;
    int           n_checked;
    int           n_fresh;

    function void note_input(heading_res_t r);
      pending.push_back(r);
    endfunction

    function void check_result(heading_res_t got);
      heading_res_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (want.fresh) n_fresh++;
      if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
      if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
      if (got.heading !== want.heading)
        report_mismatch("heading", got.heading, want.heading);
      if (got.led !== want.led) report_mismatch("lit led", got.led, want.led);
      if (got.fresh !== want.fresh) report_mismatch("fresh", got.fresh, want.fresh);
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
               n_checked);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_data_i = 1'b0;

  tcc_in_if  #(.SAMPLE_BITS(SB))      in_ch ();
  tcc_out_if #(.ANGLE_FRAC_BITS(AFB)) out_ch ();

  tilt_compensated_compass dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  compass_scoreboard sb = new();

  // predictor state
  logic        mode_q = MODE_COMPASS;
  logic [15:0] held_heading_q = '0;
  logic [2:0]  held_led_q = '0;

  bit     stall_active = 1'b0;
  bit     no_idle = 1'b0;
  int     idle_cycles = 0;
  longint atan_q30[STEPS];

  initial begin
    for (int i = 0; i < STEPS; i++) atan_q30[i] = longint'(atan_entry(IT_W'(i)));
  end

  // shifts toward minus infinity
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint vec_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = fshr(x, i);
      dy = fshr(y, i);
      if (y >= 0) begin
        x += dy; y -= dx; z += atan_q30[i];
      end else begin
        x -= dy; y += dx; z -= atan_q30[i];
      end
    end
    if (z < 0) z = 0;
    if (z > Q30_HALF_PI) z = Q30_HALF_PI;
    return z;
  endfunction

  function automatic void rot_angle(longint ang, output longint c, output longint s);
    longint x, y, dx, dy;
    x = INV_GAIN_Q30;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = fshr(x, i);
      dy = fshr(y, i);
      if (ang >= 0) begin
        x -= dy; y += dx; ang -= atan_q30[i];
      end else begin
        x += dy; y -= dx; ang += atan_q30[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint tilt_angle(longint num, longint a, longint b);
    longint r, n, ang;
    r = root_floor((a * a + b * b) <<< (2 * RADF));
    n = num < 0 ? -num : num;
    if (n == 0 && r == 0) return 0;
    ang = vec_angle(r <<< 16, n <<< (RADF + 16));
    return num < 0 ? -ang : ang;
  endfunction

  function automatic longint q30_round(longint v);
    return fshr(v + (64'sd1 <<< (29 - AFB)), 30 - AFB);
  endfunction

  function automatic logic [2:0] led_of(longint h);
    if (h >= sector_bound(300, AFB) && h < sector_bound(1150, AFB)) return 3'd3;
    if (h >= sector_bound(1150, AFB) && h < sector_bound(2200, AFB)) return 3'd2;
    if (h >= sector_bound(2200, AFB) && h < sector_bound(3050, AFB)) return 3'd1;
    if (h >= sector_bound(3050, AFB) && h < sector_bound(3700, AFB)) return 3'd0;
    if (h >= sector_bound(3700, AFB) && h < sector_bound(4400, AFB)) return 3'd7;
    if (h >= sector_bound(4400, AFB) && h < sector_bound(5200, AFB)) return 3'd6;
    if (h >= sector_bound(5200, AFB) && h < sector_bound(5800, AFB)) return 3'd5;
    return 3'd4;
  endfunction

  // heading and tilt of one sample set, updating the held heading
  function automatic heading_res_t predict_heading(sample_set_t s);
    heading_res_t res;
    longint ax, ay, az, mx, my, mz, p, r, pq, rq;
    longint cp, sp, cr, sr, cx, cy, ux, uy, a, h, hq, tp;
    ax = s.ax; ay = s.ay; az = s.az; mx = s.mx; my = s.my; mz = s.mz;
    p = tilt_angle(ax, ay, az);
    r = tilt_angle(ay, ax, az);
    pq = q30_round(p);
    rq = q30_round(r);
    res.fresh = 1'b0;
    if (mode_q == MODE_TILT) begin
      if (pq < 0) pq = -pq;
      if (rq < 0) rq = -rq;
    end else begin
      rot_angle(p, cp, sp);
      rot_angle(r, cr, sr);
      cx = mx * cp + mz * sp;
      cy = mx * fshr(sr * sp, 30) + my * cr - mz * fshr(sr * cp, 30);
      ux = (cx < 0 ? -cx : cx) >>> 7;
      uy = (cy < 0 ? -cy : cy) >>> 7;
      if (ux != 0 || uy != 0) begin
        a = vec_angle(ux, uy);
        if (cx >= 0 && cy >= 0) h = a;
        else if (cx < 0 && cy >= 0) h = Q30_PI - a;
        else if (cx < 0) h = Q30_PI + a;
        else h = Q30_TWO_PI - a;
        hq = q30_round(h);
        tp = q30_round(Q30_TWO_PI);
        if (hq >= tp) hq -= tp;
        held_heading_q = hq[15:0];
        held_led_q = led_of(hq);
        res.fresh = 1'b1;
      end
    end
    res.pitch = pq[14:0];
    res.roll = rq[14:0];
    res.heading = held_heading_q;
    res.led = held_led_q;
    return res;
  endfunction

  // random sample; edges of the range now and then
  function automatic logic signed [SB-1:0] rand_axis();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return $signed(16'($urandom_range(0, 8))) - 4;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  function automatic sample_set_t rand_set();
    sample_set_t s;
    s.ax = rand_axis(); s.ay = rand_axis(); s.az = rand_axis();
    s.mx = rand_axis(); s.my = rand_axis(); s.mz = rand_axis();
    return s;
  endfunction

  function automatic sample_set_t mk(int ax, int ay, int az, int mx, int my, int mz);
    sample_set_t s;
    s.ax = ax; s.ay = ay; s.az = az; s.mx = mx; s.my = my; s.mz = mz;
    return s;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 19);
  endfunction

  // sender: offer one transaction and wait for acceptance
  task automatic send_set(sample_set_t s);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.accel_x <= s.ax; in_ch.accel_y <= s.ay; in_ch.accel_z <= s.az;
    in_ch.mag_x <= s.mx; in_ch.mag_y <= s.my; in_ch.mag_z <= s.mz;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(predict_heading(s));
  endtask

  // wait until every result is back, then let the block go quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
  endtask

  // receiver with random stalls and a single long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.pitch_angle, out_ch.roll_angle, out_ch.heading_angle,
                         out_ch.lit_led, out_ch.heading_fresh});
      if (stall_active) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !idle_now();
      end
    end
  end

  // long hold-off in its own process
  initial begin
    @(posedge rst_ni);
    while (sb.n_checked < 60) @(posedge clk_i);
    stall_active = 1'b1;
    repeat (2000) @(posedge clk_i);
    stall_active = 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    sample_set_t s;
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
    in_ch.mag_x = '0; in_ch.mag_y = '0; in_ch.mag_z = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: compass mode after reset
    send_set(mk(0, 0, 0, 0, 0, 0));              // all zero, heading undefined
    send_set(mk(0, 0, 16384, 0, 0, 0));          // level, no field
    send_set(mk(0, 0, 16384, 1000, 0, 0));       // north, my zero
    send_set(mk(0, 0, 16384, -1000, 0, 0));
    send_set(mk(0, 0, 16384, 0, 1000, 0));       // mx zero
    send_set(mk(0, 0, 16384, 0, -1000, 0));
    send_set(mk(0, 0, 16384, 1000, -1, 0));      // close to two pi
    send_set(mk(5000, 0, 0, 300, 200, 100));     // zero denominator pitch
    send_set(mk(-5000, 0, 0, 300, 200, 100));
    send_set(mk(0, 7000, 0, 300, 200, 100));
    send_set(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    send_set(mk(32767, 32767, 32767, 32767, 32767, 32767));
    send_set(mk(-32768, 32767, 0, 32767, -32768, 32767));
    for (int i = 0; i < 8; i++)
      send_set(mk(1000, -2000, 15000, $rtoi(8000.0 * $cos(0.8 * i)),
                  $rtoi(8000.0 * $sin(0.8 * i)), 500));
    drain();

    // directed: tilt mode
    write_mode(MODE_TILT);
    send_set(mk(-9000, -4000, 12000, 0, 0, 0));
    send_set(mk(-32768, -32768, 0, 1, 2, 3));
    send_set(mk(0, 0, 0, 5, 5, 5));
    drain();

    // random phases across both modes, one without idling
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph % 2 == 0 ? MODE_COMPASS : MODE_TILT);
      no_idle = (ph == 2);
      for (int i = 0; i < 165; i++) begin
        s = rand_set();
        send_set(s);
      end
      drain();
    end
    no_idle = 1'b0;

    $display("checked %0d results, %0d with a fresh heading, in tilt and compass mode",
             sb.n_checked, sb.n_fresh);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- tilt_compensated_compass.f -----
src/tcc_pkg.sv
src/tcc_if.sv
src/tcc_cordic.sv
src/tcc_isqrt.sv
src/tilt_compensated_compass.sv
tb/sv/tb_tilt_compensated_compass.sv
